// ===== hw/rtl/gvs_pkg.sv =====
package gvs_pkg;

  // item operation carried in s_axis_tuser
  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_START = 2'd1,
    OP_END   = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    CMD_MUL  = 2'd0,
    CMD_DIV  = 2'd1,
    CMD_SQRT = 2'd2
  } arith_cmd_e;

  localparam int unsigned ARITH_W = 128;
  localparam int unsigned STEPS_W = 7;

  typedef struct packed {
    logic                 start;
    arith_cmd_e           cmd;
    logic [STEPS_W-1:0]   steps;
  } arith_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } arith_stat_t;

endpackage

// ===== hw/rtl/gvs_arith.sv =====
// Shared bit-serial unit: shift-add multiply, restoring divide (96-bit
// numerator), digit-by-digit square root. One bit (or one root digit) a cycle.
module gvs_arith (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  gvs_pkg::arith_ctrl_t         ctrl_i,
  input  logic [gvs_pkg::ARITH_W-1:0]  op_a_i,
  input  logic [gvs_pkg::ARITH_W-1:0]  op_b_i,
  output gvs_pkg::arith_stat_t         stat_o,
  output logic [gvs_pkg::ARITH_W-1:0]  res_o
);
  import gvs_pkg::*;

  logic [ARITH_W-1:0] x_q, y_q, acc_q;
  logic [129:0]       rem_q;
  logic [STEPS_W-1:0] cnt_q;
  arith_cmd_e         cmd_q;
  logic               busy_q, done_q;

  logic [129:0] remn, sub_b;
  logic [130:0] diff;
  logic         ge;

  always_comb begin
    if (cmd_q == CMD_SQRT) begin
      remn  = {rem_q[127:0], x_q[127:126]};
      sub_b = {64'b0, acc_q[63:0], 2'b01};
    end else begin
      remn  = {rem_q[128:0], x_q[95]};
      sub_b = {2'b00, y_q};
    end
    diff = {1'b0, remn} - {1'b0, sub_b};
    ge   = ~diff[130];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == STEPS_W'(1));
      if (ctrl_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= ctrl_i.steps;
      end else if (busy_q) begin
        cnt_q <= cnt_q - STEPS_W'(1);
        if (cnt_q == STEPS_W'(1)) busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      cmd_q <= ctrl_i.cmd;
      x_q   <= op_a_i;
      y_q   <= op_b_i;
      acc_q <= '0;
      rem_q <= '0;
    end else if (busy_q) begin
      unique case (cmd_q)
        CMD_MUL: begin
          if (y_q[0]) acc_q <= acc_q + x_q;
          x_q <= x_q << 1;
          y_q <= y_q >> 1;
        end
        CMD_DIV: begin
          rem_q <= ge ? diff[129:0] : remn;
          acc_q <= {acc_q[ARITH_W-2:0], ge};
          x_q   <= x_q << 1;
        end
        CMD_SQRT: begin
          rem_q <= ge ? diff[129:0] : remn;
          acc_q <= {acc_q[ARITH_W-2:0], ge};
          x_q   <= x_q << 2;
        end
        default: acc_q <= acc_q;
      endcase
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign res_o       = acc_q;

endmodule

// ===== hw/rtl/gravity_verlet_step.sv =====
// Channel   Dir  Handshake                      Payload
// s_axis    in   s_axis_tvalid/s_axis_tready    op (tuser), body/attractor (tdata), tlast
// m_axis    out  m_axis_tvalid/m_axis_tready    new position/velocity (tdata), singular (tuser)
// cfg       in   cfg_valid_i/cfg_ready_o        step_time, Q8.24
//
// Loads and ignored items are handled in the transfer cycle. An attractor runs
// on the single bit-serial mul/div/sqrt unit: three 64-step squares, a
// 64-step root, a 96-step divide for GM/d2, then per axis a 96-step divide
// and a 31-step multiply. Closing a start phase adds the position update,
// closing an end phase the velocity update. Reset clears phase to "waiting for load".
// Input stalls while an item is in work; a waiting result blocks only the emit.
module gravity_verlet_step #(
  parameter int unsigned POSITION_WIDTH = 48,
  localparam int unsigned IN_W  = ((6 * POSITION_WIDTH + 48 + 7) / 8) * 8,
  localparam int unsigned OUT_W = ((6 * POSITION_WIDTH + 7) / 8) * 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [IN_W-1:0]  s_axis_tdata,   // px, py, pz, vx, vy, vz, gm
  input  logic [1:0]       s_axis_tuser,   // operation
  input  logic             s_axis_tlast,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [OUT_W-1:0] m_axis_tdata,   // new_x, new_y, new_z, new_vx, new_vy, new_vz
  output logic             m_axis_tuser,   // singular
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [31:0]      cfg_data_i
);
  import gvs_pkg::*;

  localparam int unsigned PW = POSITION_WIDTH;
  localparam logic signed [79:0] PMAX = (80'sd1 <<< (PW - 1)) - 80'sd1;
  localparam logic signed [79:0] PMIN = -(80'sd1 <<< (PW - 1));
  localparam logic signed [65:0] S64MAX = 66'sd9223372036854775807;
  localparam logic signed [65:0] S64MIN = -66'sd9223372036854775808;
  localparam logic [31:0] STEP_TIME_RESET = 32'd279620;

  typedef enum logic [1:0] {PH_WAIT, PH_START, PH_END} phase_e;

  typedef enum logic [22:0] {
    S_IDLE   = 23'h000001, S_DIFF   = 23'h000002, S_SQ     = 23'h000004,
    S_SQ_W   = 23'h000008, S_SQRT   = 23'h000010, S_SQRT_W = 23'h000020,
    S_GDIV   = 23'h000040, S_GDIV_W = 23'h000080, S_UDIV   = 23'h000100,
    S_UDIV_W = 23'h000200, S_GMUL   = 23'h000400, S_GMUL_W = 23'h000800,
    S_AEND   = 23'h001000, S_DT2    = 23'h002000, S_DT2_W  = 23'h004000,
    S_T1     = 23'h008000, S_T1_W   = 23'h010000, S_T2     = 23'h020000,
    S_T2_W   = 23'h040000, S_VSUM   = 23'h080000, S_VMUL   = 23'h100000,
    S_VMUL_W = 23'h200000, S_EMIT   = 23'h400000
  } state_e;

  function automatic logic signed [79:0] sx80(input logic [PW-1:0] v);
    return {{(80 - PW){v[PW-1]}}, v};
  endfunction

  function automatic logic [63:0] sat64(input logic signed [65:0] v);
    if (v > S64MAX) return S64MAX[63:0];
    else if (v < S64MIN) return S64MIN[63:0];
    return v[63:0];
  endfunction

  function automatic logic [PW-1:0] sat_pw(input logic signed [79:0] v);
    if (v > PMAX) return PMAX[PW-1:0];
    else if (v < PMIN) return PMIN[PW-1:0];
    return v[PW-1:0];
  endfunction

  state_e state_q, state_d;
  phase_e phase_q, phase_d;
  logic   m_valid_q, m_valid_d;
  logic [31:0] dt_q;

  op_e              op_q;
  logic             last_q;
  logic [PW-1:0]    apos_q [3];
  logic [47:0]      gm_q;
  logic [PW-1:0]    pos_q [3];
  logic [PW-1:0]    vel_q [3];
  logic [63:0]      acc0_q [3];
  logic [63:0]      acc1_q [3];
  logic             sing_q;
  logic [63:0]      mag_q [3];
  logic             neg_q [3];
  logic [127:0]     d2_q;
  logic [63:0]      d_q;
  logic [62:0]      g_q;
  logic [30:0]      u_q;
  logic [63:0]      dt2_q;
  logic signed [79:0] tmp_q;
  logic [64:0]      smag_q;
  logic             sneg_q;
  logic [1:0]       idx_q;
  logic [6*PW-1:0]  m_data_q;
  logic             m_user_q;

  arith_ctrl_t  actrl;
  arith_stat_t  astat;
  logic [127:0] op_a, op_b, ares;

  gvs_arith u_arith (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (actrl),
    .op_a_i (op_a),
    .op_b_i (op_b),
    .stat_o (astat),
    .res_o  (ares)
  );

  // input unpacking
  op_e           in_op;
  logic [PW-1:0] in_p [3];
  logic [PW-1:0] in_v [3];
  logic          in_fire, attr_ok, idx_last, emit_go;

  always_comb begin
    in_op = op_e'(s_axis_tuser);
    for (int k = 0; k < 3; k++) begin
      in_p[k] = s_axis_tdata[k*PW +: PW];
      in_v[k] = s_axis_tdata[(k+3)*PW +: PW];
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign attr_ok  = (in_op == OP_START && phase_q == PH_START) ||
                    (in_op == OP_END && phase_q == PH_END);
  assign idx_last = (idx_q == 2'd2);
  assign emit_go  = (state_q == S_EMIT) && (!m_valid_q || m_axis_tready);
  assign cfg_ready_o = 1'b1;

  // per-axis arithmetic around the shared unit
  logic signed [65:0]  rdiff;
  logic [63:0]         rsat, rmag;
  logic [127:0]        d2_new;
  logic [63:0]         acc_sel, acc_new, term;
  logic signed [65:0]  term_s;
  logic signed [79:0]  vabs80, t1_ext, t2_ext, vt_ext;
  logic [63:0]         a0abs;
  logic signed [64:0]  s65;
  logic [64:0]         s65abs;

  always_comb begin
    rdiff  = 66'(sx80(apos_q[idx_q])) - 66'(sx80(pos_q[idx_q]));
    rsat   = sat64(rdiff);
    rmag   = rsat[63] ? -rsat : rsat;
    d2_new = d2_q + ares;
    acc_sel = (op_q == OP_START) ? acc0_q[idx_q] : acc1_q[idx_q];
    term    = ares[93:30];
    term_s  = neg_q[idx_q] ? -{2'b00, term} : {2'b00, term};
    acc_new = sat64({{2{acc_sel[63]}}, acc_sel} + term_s);
    vabs80  = vel_q[idx_q][PW-1] ? -sx80(vel_q[idx_q]) : sx80(vel_q[idx_q]);
    a0abs   = acc0_q[idx_q][63] ? -acc0_q[idx_q] : acc0_q[idx_q];
    t1_ext  = {8'b0, ares[95:24]};
    t2_ext  = {17'b0, ares[127:65]};
    vt_ext  = {24'b0, ares[96:41]};
    s65     = {acc0_q[idx_q][63], acc0_q[idx_q]} + {acc1_q[idx_q][63], acc1_q[idx_q]};
    s65abs  = s65[64] ? -s65 : s65;
  end

  // sequencer
  always_comb begin
    state_d   = state_q;
    phase_d   = phase_q;
    m_valid_d = m_valid_q && !m_axis_tready;
    actrl       = '0;
    actrl.cmd   = CMD_MUL;
    op_a        = '0;
    op_b        = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (in_op == OP_LOAD) phase_d = PH_START;
          else if (attr_ok) state_d = S_DIFF;
        end
      end
      S_DIFF: if (idx_last) state_d = S_SQ;
      S_SQ: begin
        actrl.start = 1'b1;
        actrl.steps = 7'd64;
        op_a = {64'b0, mag_q[idx_q]};
        op_b = {64'b0, mag_q[idx_q]};
        state_d = S_SQ_W;
      end
      S_SQ_W: begin
        if (astat.done) begin
          if (!idx_last) state_d = S_SQ;
          else if (d2_new == '0) state_d = S_AEND;
          else state_d = S_SQRT;
        end
      end
      S_SQRT: begin
        actrl.start = 1'b1;
        actrl.cmd   = CMD_SQRT;
        actrl.steps = 7'd64;
        op_a = d2_q;
        state_d = S_SQRT_W;
      end
      S_SQRT_W: if (astat.done) state_d = S_GDIV;
      S_GDIV: begin
        actrl.start = 1'b1;
        actrl.cmd   = CMD_DIV;
        actrl.steps = 7'd96;
        op_a = {32'b0, gm_q, 48'b0};
        op_b = d2_q;
        state_d = S_GDIV_W;
      end
      S_GDIV_W: if (astat.done) state_d = S_UDIV;
      S_UDIV: begin
        actrl.start = 1'b1;
        actrl.cmd   = CMD_DIV;
        actrl.steps = 7'd96;
        op_a = {34'b0, mag_q[idx_q], 30'b0};
        op_b = {64'b0, d_q};
        state_d = S_UDIV_W;
      end
      S_UDIV_W: if (astat.done) state_d = S_GMUL;
      S_GMUL: begin
        actrl.start = 1'b1;
        actrl.steps = 7'd31;
        op_a = {65'b0, g_q};
        op_b = {97'b0, u_q};
        state_d = S_GMUL_W;
      end
      S_GMUL_W: if (astat.done) state_d = idx_last ? S_AEND : S_UDIV;
      S_AEND: begin
        if (!last_q) state_d = S_IDLE;
        else if (op_q == OP_START) state_d = S_DT2;
        else state_d = S_VSUM;
      end
      S_DT2: begin
        actrl.start = 1'b1;
        actrl.steps = 7'd32;
        op_a = {96'b0, dt_q};
        op_b = {96'b0, dt_q};
        state_d = S_DT2_W;
      end
      S_DT2_W: if (astat.done) state_d = S_T1;
      S_T1: begin
        actrl.start = 1'b1;
        actrl.steps = 7'd32;
        op_a = {64'b0, vabs80[63:0]};
        op_b = {96'b0, dt_q};
        state_d = S_T1_W;
      end
      S_T1_W: if (astat.done) state_d = S_T2;
      S_T2: begin
        actrl.start = 1'b1;
        actrl.steps = 7'd64;
        op_a = {64'b0, a0abs};
        op_b = {64'b0, dt2_q};
        state_d = S_T2_W;
      end
      S_T2_W: begin
        if (astat.done) begin
          if (idx_last) begin
            phase_d = PH_END;
            state_d = S_IDLE;
          end else begin
            state_d = S_T1;
          end
        end
      end
      S_VSUM: state_d = S_VMUL;
      S_VMUL: begin
        actrl.start = 1'b1;
        actrl.steps = 7'd32;
        op_a = {63'b0, smag_q};
        op_b = {96'b0, dt_q};
        state_d = S_VMUL_W;
      end
      S_VMUL_W: if (astat.done) state_d = idx_last ? S_EMIT : S_VSUM;
      S_EMIT: begin
        if (emit_go) begin
          m_valid_d = 1'b1;
          phase_d   = PH_START;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      phase_q   <= PH_WAIT;
      m_valid_q <= 1'b0;
      dt_q      <= STEP_TIME_RESET;
    end else begin
      state_q   <= state_d;
      phase_q   <= phase_d;
      m_valid_q <= m_valid_d;
      if (cfg_valid_i && cfg_ready_o) dt_q <= cfg_data_i;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          op_q   <= in_op;
          last_q <= s_axis_tlast;
          gm_q   <= s_axis_tdata[6*PW +: 48];
          idx_q  <= 2'd0;
          d2_q   <= '0;
          for (int k = 0; k < 3; k++) apos_q[k] <= in_p[k];
          if (in_op == OP_LOAD) begin
            sing_q <= 1'b0;
            for (int k = 0; k < 3; k++) begin
              pos_q[k]  <= in_p[k];
              vel_q[k]  <= in_v[k];
              acc0_q[k] <= '0;
              acc1_q[k] <= '0;
            end
          end
        end
      end
      S_DIFF: begin
        mag_q[idx_q] <= rmag;
        neg_q[idx_q] <= rsat[63];
        idx_q <= idx_last ? 2'd0 : idx_q + 2'd1;
      end
      S_SQ_W: begin
        if (astat.done) begin
          d2_q  <= d2_new;
          idx_q <= idx_last ? 2'd0 : idx_q + 2'd1;
          if (idx_last && d2_new == '0) sing_q <= 1'b1;
        end
      end
      S_SQRT_W: if (astat.done) d_q <= ares[63:0];
      S_GDIV_W: if (astat.done) g_q <= (|ares[95:63]) ? '1 : ares[62:0];
      S_UDIV_W: if (astat.done) u_q <= ares[30:0];
      S_GMUL_W: begin
        if (astat.done) begin
          if (op_q == OP_START) acc0_q[idx_q] <= acc_new;
          else acc1_q[idx_q] <= acc_new;
          idx_q <= idx_last ? 2'd0 : idx_q + 2'd1;
        end
      end
      S_DT2_W: if (astat.done) dt2_q <= ares[63:0];
      S_T1_W: begin
        if (astat.done)
          tmp_q <= sx80(pos_q[idx_q]) + (vel_q[idx_q][PW-1] ? -t1_ext : t1_ext);
      end
      S_T2_W: begin
        if (astat.done) begin
          pos_q[idx_q] <= sat_pw(tmp_q + (acc0_q[idx_q][63] ? -t2_ext : t2_ext));
          idx_q <= idx_last ? 2'd0 : idx_q + 2'd1;
        end
      end
      S_VSUM: begin
        smag_q <= s65abs;
        sneg_q <= s65[64];
      end
      S_VMUL_W: begin
        if (astat.done) begin
          vel_q[idx_q] <= sat_pw(sx80(vel_q[idx_q]) + (sneg_q ? -vt_ext : vt_ext));
          idx_q <= idx_last ? 2'd0 : idx_q + 2'd1;
        end
      end
      S_EMIT: begin
        if (emit_go) begin
          m_data_q <= {vel_q[2], vel_q[1], vel_q[0], pos_q[2], pos_q[1], pos_q[0]};
          m_user_q <= sing_q;
          sing_q   <= 1'b0;
          for (int k = 0; k < 3; k++) begin
            acc0_q[k] <= '0;
            acc1_q[k] <= '0;
          end
        end
      end
      default: idx_q <= idx_q;
    endcase
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = OUT_W'(m_data_q);
  assign m_axis_tuser  = m_user_q;

endmodule

// ===== hw/rtl/gvs_checker.sv =====
module gvs_checker #(
  parameter int unsigned POSITION_WIDTH = 48,
  localparam int unsigned OUT_W = ((6 * POSITION_WIDTH + 7) / 8) * 8
) (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             s_axis_tvalid,
  input logic             s_axis_tready,
  input logic [1:0]       s_axis_tuser,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [OUT_W-1:0] m_axis_tdata
);
  import gvs_pkg::*;

  logic in_xfer;
  assign in_xfer = s_axis_tvalid && s_axis_tready;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // loads and unused ops finish in the transfer cycle
  a_quick_ops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && (s_axis_tuser == OP_LOAD || s_axis_tuser == OP_NONE) |=> s_axis_tready)
    else $error("load or unused op did not return to idle");

  // a result never appears right after an input transfer
  a_no_fast_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !$rose(m_axis_tvalid))
    else $error("result right after input transfer");

  // a new result comes from the emit step, with input held off
  a_emit_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result raised while input was open");

endmodule

bind gravity_verlet_step gvs_checker #(.POSITION_WIDTH(POSITION_WIDTH)) u_gvs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
